// File: design/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared constants and types of the best-fit allocator: field widths,
// default sizes, operation codes and the command word passed front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package bfa_pkg;

    localparam int BFA_MAX_BLOCKS  = 16;
    localparam int BFA_SIZE_WIDTH  = 16;
    localparam int BFA_FIELD_W     = 16;
    localparam int BFA_SLOT_W      = 4;
    localparam int BFA_COUNT_W     = 5;
    localparam int BFA_COUNT_RESET = 16;
    localparam int BFA_QUEUE_DEPTH = 4;

    typedef enum logic {
        BFA_OP_LOAD    = 1'b0,
        BFA_OP_REQUEST = 1'b1
    } bfa_op_t;

    typedef struct packed {
        bfa_op_t                  op;
        logic [BFA_FIELD_W-1:0]   size;
        logic [BFA_SLOT_W-1:0]    slot;
        logic                     last;
    } bfa_cmd_t;

endpackage

`default_nettype wire

// File: design/bfa_ram.sv
// ----------------------------------------------------------------------------
// bfa_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: design/bfa_front.sv
// ----------------------------------------------------------------------------
// bfa_front
// Input side: takes items, drops loads aimed past the table, and queues the
// remaining commands for the execution side.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_front
    import bfa_pkg::*;
#(
    parameter int MAX_BLOCKS = BFA_MAX_BLOCKS
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   req_valid,
    output logic                        req_stall,
    input  wire logic                   mode,
    input  wire logic [BFA_FIELD_W-1:0] size_value,
    input  wire logic [BFA_SLOT_W-1:0]  slot_index,
    input  wire logic                   last_request,
    output logic                        cmd_valid,
    output bfa_cmd_t                    cmd,
    input  wire logic                   cmd_pop
);

    localparam int PTR_W = (BFA_QUEUE_DEPTH > 1) ? $clog2(BFA_QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(BFA_QUEUE_DEPTH + 1);

    bfa_cmd_t          entries_reg [BFA_QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    bfa_cmd_t          in_cmd;
    logic              keep;
    logic              push;
    logic              pop;

    always_comb
    begin
        in_cmd.op   = bfa_op_t'(mode);
        in_cmd.size = size_value;
        in_cmd.slot = slot_index;
        in_cmd.last = last_request;
    end

    // loads past the end of the table have no effect
    assign keep      = (in_cmd.op == BFA_OP_REQUEST) || (int'(slot_index) < MAX_BLOCKS);
    assign req_stall = (count_reg == CNT_W'(BFA_QUEUE_DEPTH));
    assign push      = req_valid && !req_stall && keep;
    assign pop       = cmd_pop && cmd_valid;
    assign cmd_valid = (count_reg != '0);
    assign cmd       = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_reg + CNT_W'(push) - CNT_W'(pop);
        end
    end

endmodule

`default_nettype wire

// File: design/bfa_back.sv
// ----------------------------------------------------------------------------
// bfa_back
// Execution side: writes loads into the free-size table, scans the table one
// entry per cycle for the best fit, updates the winner and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_back
    import bfa_pkg::*;
#(
    parameter int MAX_BLOCKS = BFA_MAX_BLOCKS,
    parameter int SIZE_WIDTH = BFA_SIZE_WIDTH
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [BFA_COUNT_W-1:0] block_count,
    input  wire logic                   cmd_valid,
    input  wire bfa_cmd_t               cmd,
    output logic                        cmd_pop,
    output logic                        rsp_valid,
    input  wire logic                   rsp_stall,
    output logic                        granted,
    output logic      [BFA_SLOT_W-1:0]  chosen_block,
    output logic      [BFA_FIELD_W-1:0] remaining_size,
    output logic                        last
);

    localparam int IDX_W     = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int LIM_W     = $clog2(MAX_BLOCKS + 1);
    localparam int LIM_RESET = (BFA_COUNT_RESET > MAX_BLOCKS) ? MAX_BLOCKS : BFA_COUNT_RESET;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t                  state_reg;
    logic [LIM_W-1:0]        limit_reg;
    logic [SIZE_WIDTH-1:0]   size_reg;
    logic                    last_reg;
    logic [IDX_W-1:0]        cnt_reg;
    logic                    found_reg;
    logic [IDX_W-1:0]        best_idx_reg;
    logic [SIZE_WIDTH-1:0]   best_val_reg;
    logic                    rsp_valid_reg;
    logic                    granted_reg;
    logic [BFA_SLOT_W-1:0]   chosen_reg;
    logic [BFA_FIELD_W-1:0]  remaining_reg;
    logic                    rsp_last_reg;

    logic [LIM_W-1:0]        cfg_limit;
    logic [SIZE_WIDTH-1:0]   head_size;
    logic [IDX_W-1:0]        head_slot;
    logic                    rsp_free;
    logic [SIZE_WIDTH-1:0]   rd_data;
    logic                    fits;
    logic                    better;
    logic                    scan_done;
    logic [SIZE_WIDTH-1:0]   remain;
    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [SIZE_WIDTH-1:0]   ram_wdata;
    logic [IDX_W-1:0]        ram_raddr;

    bfa_ram #(
        .WIDTH (SIZE_WIDTH),
        .DEPTH (MAX_BLOCKS),
        .ADDR_W(IDX_W)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(rd_data)
    );

    // counts above the table size saturate
    assign cfg_limit = (int'(block_count) > MAX_BLOCKS) ? LIM_W'(MAX_BLOCKS)
                                                         : LIM_W'(block_count);

    assign head_size = SIZE_WIDTH'(cmd.size);
    assign head_slot = IDX_W'(cmd.slot);
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign fits      = (rd_data >= size_reg);
    // strict compare keeps the lowest index on ties
    assign better    = !found_reg || (rd_data < best_val_reg);
    assign scan_done = ((LIM_W'(cnt_reg) + LIM_W'(1)) == limit_reg);
    assign remain    = best_val_reg - size_reg;
    assign cmd_pop   = (state_reg == ST_IDLE) && cmd_valid;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = head_slot;
        ram_wdata = head_size;
        ram_raddr = '0;
        case (state_reg)
            ST_IDLE:
            begin
                ram_we = cmd_valid && (cmd.op == BFA_OP_LOAD);
            end
            ST_SCAN:
            begin
                // data of entry cnt is on the read port, fetch the next one
                ram_raddr = cnt_reg + IDX_W'(1);
            end
            ST_FINISH:
            begin
                ram_waddr = best_idx_reg;
                ram_wdata = remain;
                ram_we    = rsp_free && found_reg;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            limit_reg     <= LIM_W'(LIM_RESET);
            size_reg      <= '0;
            last_reg      <= 1'b0;
            cnt_reg       <= '0;
            found_reg     <= 1'b0;
            best_idx_reg  <= '0;
            best_val_reg  <= '0;
            rsp_valid_reg <= 1'b0;
            granted_reg   <= 1'b0;
            chosen_reg    <= '0;
            remaining_reg <= '0;
            rsp_last_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                limit_reg <= cfg_limit;
            end
            // the finish state loads a new word itself when the register frees
            if (rsp_valid_reg && !rsp_stall && (state_reg != ST_FINISH))
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_valid && (cmd.op == BFA_OP_REQUEST))
                    begin
                        size_reg  <= head_size;
                        last_reg  <= cmd.last;
                        found_reg <= 1'b0;
                        cnt_reg   <= '0;
                        state_reg <= (limit_reg == '0) ? ST_FINISH : ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (fits && better)
                    begin
                        found_reg    <= 1'b1;
                        best_idx_reg <= cnt_reg;
                        best_val_reg <= rd_data;
                    end
                    cnt_reg <= cnt_reg + IDX_W'(1);
                    if (scan_done)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (rsp_free)
                    begin
                        rsp_valid_reg <= 1'b1;
                        granted_reg   <= found_reg;
                        chosen_reg    <= found_reg ? BFA_SLOT_W'(best_idx_reg) : '0;
                        remaining_reg <= found_reg ? BFA_FIELD_W'(remain) : '0;
                        rsp_last_reg  <= last_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rsp_valid      = rsp_valid_reg;
    assign granted        = granted_reg;
    assign chosen_block   = chosen_reg;
    assign remaining_size = remaining_reg;
    assign last           = rsp_last_reg;

endmodule

`default_nettype wire

// File: design/best_fit_allocator.sv
// ----------------------------------------------------------------------------
// best_fit_allocator
// Best-fit allocation over a table of partition free sizes.
// ----------------------------------------------------------------------------
// Input channel req_valid/req_stall carries one word per item: mode 0 loads
// size_value into partition slot_index, mode 1 requests size_value. Loads
// give no result; each request gives one word on rsp_valid/rsp_stall with
// granted, chosen_block, remaining_size and last (echo of last_request).
// Configuration channel cfg_valid/cfg_ready writes block_count, the number
// of partitions scanned from zero; cfg_ready is always high.
// Words go through a four-entry command queue into the execution side.
// There a load is written into the table from the queue head. A request
// is issued, scans block_count entries (one table read per cycle out of
// the table memory), then, once the output register is free, writes back
// the winner's remaining size and loads the result word.
// Reset sets block_count to 16 (capped at MAX_BLOCKS) and empties the queue
// and output register; table contents stay unknown until loaded.
// While rsp_stall is high the result is held, the execution side waits
// and the queue fills; req_stall rises once the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module best_fit_allocator
    import bfa_pkg::*;
#(
    parameter int MAX_BLOCKS = BFA_MAX_BLOCKS,
    parameter int SIZE_WIDTH = BFA_SIZE_WIDTH
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [BFA_COUNT_W-1:0] block_count,
    input  wire logic                   req_valid,
    output logic                        req_stall,
    input  wire logic                   mode,
    input  wire logic [BFA_FIELD_W-1:0] size_value,
    input  wire logic [BFA_SLOT_W-1:0]  slot_index,
    input  wire logic                   last_request,
    output logic                        rsp_valid,
    input  wire logic                   rsp_stall,
    output logic                        granted,
    output logic      [BFA_SLOT_W-1:0]  chosen_block,
    output logic      [BFA_FIELD_W-1:0] remaining_size,
    output logic                        last
);

    bfa_cmd_t cmd;
    logic     cmd_valid;
    logic     cmd_pop;

    assign cfg_ready = 1'b1;

    bfa_front #(
        .MAX_BLOCKS(MAX_BLOCKS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .mode        (mode),
        .size_value  (size_value),
        .slot_index  (slot_index),
        .last_request(last_request),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop)
    );

    bfa_back #(
        .MAX_BLOCKS(MAX_BLOCKS),
        .SIZE_WIDTH(SIZE_WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_valid && cfg_ready),
        .block_count   (block_count),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .granted       (granted),
        .chosen_block  (chosen_block),
        .remaining_size(remaining_size),
        .last          (last)
    );

endmodule

`default_nettype wire

// File: verif/best_fit_allocator_test.sv
// ----------------------------------------------------------------------------
// best_fit_allocator_test
// Self-checking bench for the best-fit allocator. A directed table and then
// random load/request traffic go in over several block_count settings and
// idle patterns. Every request result is compared with an in-bench
// best-fit predictor or, for typed directed rows, with their written values.
// ----------------------------------------------------------------------------
module best_fit_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bfa_pkg::*;

    localparam int SLOTS         = BFA_MAX_BLOCKS;
    localparam int DIR_ROWS      = 20;
    localparam int NUM_PHASES    = 8;
    localparam int RANDOM_PHASE  = 6;
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_REPORTS   = 40;

    localparam logic [BFA_COUNT_W-1:0] PHASE_COUNT [NUM_PHASES] =
        '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd8, 5'd16, 5'd16};
    localparam int PHASE_ITEMS [NUM_PHASES] = '{300, 200, 60, 260, 260, 250, 250, 300};
    localparam int PHASE_IDLE  [NUM_PHASES] = '{0, 54, 0, 12, 0, 54, 0, 12};
    localparam int PHASE_STALL [NUM_PHASES] = '{0, 0, 54, 12, 0, 0, 54, 12};

    typedef struct packed {
        logic                   granted;
        logic [BFA_SLOT_W-1:0]  block;
        logic [BFA_FIELD_W-1:0] left;
        logic                   last;
    } alloc_result_t;

    typedef struct packed {
        bfa_cmd_t      word;
        logic          typed;
        alloc_result_t result;
    } dir_row_t;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   cfg_valid    = 1'b0;
    logic                   cfg_ready;
    logic [BFA_COUNT_W-1:0] cfg_count    = '0;
    logic                   req_valid    = 1'b0;
    logic                   req_stall;
    logic                   mode         = 1'b0;
    logic [BFA_FIELD_W-1:0] size_value   = '0;
    logic [BFA_SLOT_W-1:0]  slot_index   = '0;
    logic                   last_request = 1'b0;
    logic                   rsp_valid;
    logic                   rsp_stall    = 1'b0;
    logic                   granted;
    logic [BFA_SLOT_W-1:0]  chosen_block;
    logic [BFA_FIELD_W-1:0] remaining_size;
    logic                   rsp_last;

    // predictor copy of the partition table and the scan count
    logic [BFA_FIELD_W-1:0] part_free [SLOTS];
    bit                     part_loaded [SLOTS];
    logic [BFA_COUNT_W-1:0] scan_count = BFA_COUNT_W'(BFA_COUNT_RESET);
    alloc_result_t          alloc_pending [$];

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    int          errors        = 0;
    int          words_sent    = 0;
    int          results_seen  = 0;
    int          grants_seen   = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    best_fit_allocator u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .block_count    (cfg_count),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .mode           (mode),
        .size_value     (size_value),
        .slot_index     (slot_index),
        .last_request   (last_request),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .granted        (granted),
        .chosen_block   (chosen_block),
        .remaining_size (remaining_size),
        .last           (rsp_last)
    );

    function automatic int scan_limit();
        return (scan_count > SLOTS) ? SLOTS : int'(scan_count);
    endfunction

    // returns 1 when the word gives a result
    function automatic bit best_fit_step(input bfa_cmd_t w, output alloc_result_t r);
        int pick;
        pick   = -1;
        r      = '0;
        r.last = w.last;
        if (w.op == BFA_OP_LOAD)
        begin
            part_free[w.slot]   = w.size;
            part_loaded[w.slot] = 1'b1;
            return 1'b0;
        end
        for (int j = 0; j < scan_limit(); j++)
        begin
            if (part_free[j] >= w.size && (pick < 0 || part_free[pick] > part_free[j]))
                pick = j;
        end
        if (pick >= 0)
        begin
            part_free[pick] = part_free[pick] - w.size;
            r.granted       = 1'b1;
            r.block         = BFA_SLOT_W'(pick);
            r.left          = part_free[pick];
        end
        return 1'b1;
    endfunction

    function automatic dir_row_t load_row(input int slot, input logic [BFA_FIELD_W-1:0] size);
        dir_row_t row;
        row           = '0;
        row.word.op   = BFA_OP_LOAD;
        row.word.slot = BFA_SLOT_W'(slot);
        row.word.size = size;
        return row;
    endfunction

    function automatic dir_row_t req_row(input logic [BFA_FIELD_W-1:0] size, input logic lst);
        dir_row_t row;
        row           = '0;
        row.word.op   = BFA_OP_REQUEST;
        row.word.size = size;
        row.word.last = lst;
        return row;
    endfunction

    function automatic dir_row_t typed_row(input logic [BFA_FIELD_W-1:0] size, input logic lst,
                                           input logic g, input int blk,
                                           input logic [BFA_FIELD_W-1:0] left);
        dir_row_t row;
        row                = req_row(size, lst);
        row.typed          = 1'b1;
        row.result.granted = g;
        row.result.block   = BFA_SLOT_W'(blk);
        row.result.left    = left;
        row.result.last    = lst;
        return row;
    endfunction

    function automatic bfa_cmd_t random_word();
        bfa_cmd_t    w;
        int          k;
        int unsigned roll;
        w.slot = BFA_SLOT_W'($urandom_range(SLOTS - 1));
        w.last = 1'($urandom_range(1));
        w.op   = ($urandom_range(99) < 45) ? BFA_OP_LOAD : BFA_OP_REQUEST;
        roll   = $urandom_range(99);
        if (w.op == BFA_OP_LOAD)
        begin
            // mostly refill partitions that are actually scanned
            if (scan_limit() > 0 && $urandom_range(99) < 80)
                w.slot = BFA_SLOT_W'($urandom_range(scan_limit() - 1));
            if (roll < 10)
                w.size = '0;
            else if (roll < 20)
                w.size = '1;
            else if (roll < 45)
                w.size = BFA_FIELD_W'($urandom_range(255));
            else
                w.size = BFA_FIELD_W'($urandom_range(16'hFFFF));
            return w;
        end
        if (roll < 8)
            w.size = '0;
        else if (roll < 16)
            w.size = '1;
        else if (roll < 60 && scan_limit() > 0)
        begin
            // just below, exactly at or just above a partition's free size
            k      = $urandom_range(scan_limit() - 1);
            w.size = part_free[k] - 1'b1 + BFA_FIELD_W'($urandom_range(2));
        end
        else if (roll < 80)
            w.size = BFA_FIELD_W'($urandom_range(300));
        else
            w.size = BFA_FIELD_W'($urandom_range(16'hFFFF));
        // never let a request scan a partition that holds no loaded size
        for (int j = 0; j < scan_limit(); j++)
        begin
            if (!part_loaded[j])
            begin
                w.op   = BFA_OP_LOAD;
                w.slot = BFA_SLOT_W'(j);
                w.size = BFA_FIELD_W'($urandom_range(16'hFFFF));
                return w;
            end
        end
        return w;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%0t ns: mismatch on %s, got %0h, expected %0h", $time, what, got, want);
    endtask

    task automatic send_word(input bfa_cmd_t w, input bit typed, input alloc_result_t want);
        alloc_result_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid    <= 1'b1;
        mode         <= w.op;
        size_value   <= w.size;
        slot_index   <= w.slot;
        last_request <= w.last;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        if (best_fit_step(w, predicted))
            alloc_pending.push_back(typed ? want : predicted);
        words_sent++;
    endtask

    task automatic write_count(input logic [BFA_COUNT_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_count <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid  <= 1'b0;
        scan_count  = v;
    endtask

    task automatic drain();
        while (alloc_pending.size() != 0)
            @(posedge clk);
        // loads behind the last request give no word, let them retire
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic check_result();
        alloc_result_t want;
        results_seen++;
        if (alloc_pending.size() == 0)
        begin
            report_mismatch("result word with nothing pending", 32'(chosen_block), 0);
            return;
        end
        want = alloc_pending.pop_front();
        if (granted !== want.granted)
            report_mismatch("granted", 32'(granted), 32'(want.granted));
        if (chosen_block !== want.block)
            report_mismatch("chosen_block", 32'(chosen_block), 32'(want.block));
        if (remaining_size !== want.left)
            report_mismatch("remaining_size", 32'(remaining_size), 32'(want.left));
        if (rsp_last !== want.last)
            report_mismatch("last", 32'(rsp_last), 32'(want.last));
        if (granted === 1'b1)
            grants_seen++;
    endtask

    // result side: sample with the pre-edge stall, then pick the next stall
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            check_result();
        rsp_stall <= ($urandom_range(99) < stall_pct);
    end

    initial
    begin
        dir_row_t      rows [DIR_ROWS];
        alloc_result_t none;
        none = '0;
        rows = '{
            load_row(0, 16'hFFFF),
            load_row(1, 16'd100),
            load_row(2, 16'd100),
            load_row(3, 16'd0),
            typed_row(16'd0, 1'b0, 1'b1, 3, 16'd0),        // zero size goes to smallest
            typed_row(16'd100, 1'b0, 1'b1, 1, 16'd0),      // tie, lowest index wins
            typed_row(16'd100, 1'b1, 1'b1, 2, 16'd0),
            typed_row(16'd101, 1'b0, 1'b1, 0, 16'd65434),
            typed_row(16'hFFFF, 1'b1, 1'b0, 0, 16'd0),     // no partition big enough
            req_row(16'd65434, 1'b0),
            typed_row(16'd1, 1'b1, 1'b0, 0, 16'd0),
            load_row(3, 16'hFFFF),
            load_row(2, 16'h5555),
            load_row(1, 16'hAAAA),
            typed_row(16'h5555, 1'b0, 1'b1, 2, 16'd0),
            typed_row(16'd1, 1'b1, 1'b1, 1, 16'hAAA9),
            load_row(15, 16'h1234),
            load_row(0, 16'h8000),
            req_row(16'h7FFF, 1'b0),
            typed_row(16'hFFFF, 1'b1, 1'b1, 3, 16'd0)
        };
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_count(5'd4);
        foreach (rows[i])
            send_word(rows[i].word, rows[i].typed, rows[i].result);
        req_valid <= 1'b0;
        drain();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            send_idle_pct = PHASE_IDLE[p];
            stall_pct     = PHASE_STALL[p];
            write_count((p == RANDOM_PHASE) ? BFA_COUNT_W'($urandom_range(2, 15))
                                            : PHASE_COUNT[p]);
            repeat (PHASE_ITEMS[p]) send_word(random_word(), 1'b0, none);
            req_valid <= 1'b0;
            drain();
        end

        $display("run covered %0d words in, %0d result words checked, %0d of them granted",
                 words_sent, results_seen, grants_seen);
        $display("block_count went through %0d settings from 0 to 31 with idling up to 54 pct",
                 NUM_PHASES + 1);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("timeout with %0d result words still pending", alloc_pending.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule

// File: sim.f
design/bfa_pkg.sv
design/bfa_ram.sv
design/bfa_front.sv
design/bfa_back.sv
design/best_fit_allocator.sv
verif/best_fit_allocator_test.sv
